// ----- rtl/sb64_pkg.sv -----
// ----------------------------------------------------------------------------
// sb64_pkg
// Types, status codes and the alphabet map shared by the strict base64
// decoder modules.
// ----------------------------------------------------------------------------
package sb64_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_LENGTH     = 3'd1,
    ST_BADCHAR    = 3'd2,
    ST_AFTERPAD   = 3'd3,
    ST_TOOMUCHPAD = 3'd4,
    ST_NONCANON   = 3'd5
  } status_t;

  localparam logic [7:0] CHAR_PAD   = 8'h3d;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2f;  // '/'
  localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UZ    = 8'h5a;  // 'Z'
  localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LZ    = 8'h7a;  // 'z'
  localparam logic [7:0] CHAR_D0    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_D9    = 8'h39;  // '9'

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  localparam logic [7:0] OFFSET_LOWER = 8'd26;
  localparam logic [7:0] OFFSET_DIGIT = 8'd52;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_message;
  } sym_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_done;
    status_t    status;
  } res_item_t;

  typedef struct packed {
    logic [1:0] group_position;
    logic [5:0] previous_sextet;
    logic [1:0] pad_count;
    status_t    first_error;
    logic       noncanonical_seen;
  } dec_state_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t    s;
    logic [7:0] t;
    s = '{ok: 1'b1, value: '0};
    t = '0;
    if (c >= CHAR_UA && c <= CHAR_UZ) begin
      t = c - CHAR_UA;
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      t = c - CHAR_LA + OFFSET_LOWER;
    end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
      t = c - CHAR_D0 + OFFSET_DIGIT;
    end else if (c == CHAR_PLUS) begin
      t = {2'b00, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      t = {2'b00, SEXTET_SLASH};
    end else begin
      s.ok = 1'b0;
    end
    s.value = t[5:0];
    return s;
  endfunction

endpackage

// ----- rtl/strict_base64_decoder_top.sv -----
// ----------------------------------------------------------------------------
// strict_base64_decoder_top
// Strict canonical base64 decoder, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   The sym channel carries one ASCII character per item, with end_of_message
//   set on the last character of a message. The res channel returns exactly
//   one item per character: a decoded byte with byte_valid on the 2nd, 3rd
//   and 4th data symbol of each group, and on the last character
//   message_done with the message status (ok, length, bad character, data
//   after padding, too much padding, noncanonical).
//   An accepted item is held in the input register, then moves through the
//   decode logic into the result register, where it is offered.
//   Throughput is one item per cycle while res_stall is low; the decode is
//   combinational, and the group state updates as each item moves into the
//   result register.
//   When res_stall is high the result register holds, the input register
//   still fills once, and sym_stall rises only when both are occupied.
//   Reset empties both registers and returns the group position, pad count,
//   previous sextet and error flags to zero; those state fields clear the same
//   way after every character flagged end_of_message.
// ----------------------------------------------------------------------------
module strict_base64_decoder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                sym_valid,
  output logic                sym_stall,
  input  sb64_pkg::sym_item_t sym_item,
  output logic                res_valid,
  input  logic                res_stall,
  output sb64_pkg::res_item_t res_item
);
  import sb64_pkg::*;

  logic       in_full;
  sym_item_t  in_item;
  dec_state_t state;
  dec_state_t state_next;
  res_item_t  step_res;
  logic       advance;

  assign advance   = in_full && (!res_valid || !res_stall);
  assign sym_stall = in_full && !advance;

  sb64_step u_step (
    .cur  (state),
    .item (in_item),
    .nxt  (state_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      res_valid <= 1'b0;
      state     <= '{group_position: '0, previous_sextet: '0, pad_count: '0,
                     first_error: ST_OK, noncanonical_seen: 1'b0};
    end else begin
      if (sym_valid && !sym_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
        state     <= state_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sym_valid && !sym_stall) begin
      in_item <= sym_item;
    end
    if (advance) begin
      res_item <= step_res;
    end
  end

endmodule

// ----- rtl/sb64_step.sv -----
// ----------------------------------------------------------------------------
// sb64_step
// Per-character decode: maps the symbol, forms the output byte and the
// message status, and computes the next decoder state.
// ----------------------------------------------------------------------------
module sb64_step (
  input  sb64_pkg::dec_state_t cur,
  input  sb64_pkg::sym_item_t  item,
  output sb64_pkg::dec_state_t nxt,
  output sb64_pkg::res_item_t  res
);
  import sb64_pkg::*;

  sextet_t    sx;
  logic [1:0] pos;
  logic [1:0] pos_next;
  logic [1:0] pad_next;
  status_t    err_next;
  logic       nc_next;
  logic [5:0] prev_next;
  logic [7:0] byte_val;
  logic       byte_ok;

  assign sx       = sextet_of(item.symbol);
  assign pos      = cur.group_position;
  assign pos_next = pos + 2'd1;

  always_comb begin
    pad_next  = cur.pad_count;
    err_next  = cur.first_error;
    nc_next   = cur.noncanonical_seen;
    prev_next = cur.previous_sextet;
    byte_val  = '0;
    byte_ok   = 1'b0;

    if (item.symbol == CHAR_PAD) begin
      // A pad right after a data symbol must leave no unused bits set.
      if (cur.pad_count == 2'd0) begin
        if (pos == 2'd2 && cur.previous_sextet[3:0] != 4'd0) nc_next = 1'b1;
        if (pos == 2'd3 && cur.previous_sextet[1:0] != 2'd0) nc_next = 1'b1;
      end
      if (cur.pad_count != 2'd3) pad_next = cur.pad_count + 2'd1;
      if (pad_next == 2'd3 && cur.first_error == ST_OK) err_next = ST_TOOMUCHPAD;
    end else if (cur.pad_count != 2'd0) begin
      if (cur.first_error == ST_OK) err_next = ST_AFTERPAD;
    end else if (!sx.ok) begin
      if (cur.first_error == ST_OK) err_next = ST_BADCHAR;
    end else begin
      prev_next = sx.value;
      if (cur.first_error == ST_OK && pos != 2'd0) begin
        byte_ok = 1'b1;
        unique case (pos)
          2'd1:    byte_val = {cur.previous_sextet, sx.value[5:4]};
          2'd2:    byte_val = {cur.previous_sextet[3:0], sx.value[5:2]};
          default: byte_val = {cur.previous_sextet[1:0], sx.value};
        endcase
      end
    end
  end

  always_comb begin
    res.data_byte    = byte_val;
    res.byte_valid   = byte_ok;
    res.message_done = item.end_of_message;
    res.status       = ST_OK;
    nxt.group_position    = pos_next;
    nxt.previous_sextet   = prev_next;
    nxt.pad_count         = pad_next;
    nxt.first_error       = err_next;
    nxt.noncanonical_seen = nc_next;

    if (item.end_of_message) begin
      priority if (pos_next != 2'd0) begin
        res.status = ST_LENGTH;
      end else if (err_next != ST_OK) begin
        res.status = err_next;
      end else if (nc_next) begin
        res.status = ST_NONCANON;
      end else begin
        res.status = ST_OK;
      end
      // The next message starts from a clean state.
      nxt = '{group_position: '0, previous_sextet: '0, pad_count: '0,
              first_error: ST_OK, noncanonical_seen: 1'b0};
    end
  end

endmodule
